FILE: src/rcat_pkg.sv
// Shared constants, codes and types of the reference count aging table.
package rcat_pkg;

  // Table geometry
  localparam int CAPACITY = 64;
  localparam int REF_BITS = 16;
  localparam int KEY_W    = 32;
  localparam int MARK_W   = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > MARK_W) ? CNT_W : MARK_W;

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

  // Request types
  localparam logic REQ_REF   = 1'b0;
  localparam logic REQ_CLEAN = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REFUSED  = 3'd2;
  localparam logic [2:0] ST_CLEANED  = 3'd3;
  localparam logic [2:0] ST_SKIPPED  = 3'd4;

  // Configuration register indexes
  localparam logic REG_HIGH_MARK = 1'b0;
  localparam logic REG_LOW_MARK  = 1'b1;

  // One table entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [REF_BITS-1:0] refs;
  } ent_t;

  // Command from the front end to the scan engine
  typedef struct packed {
    logic             clean;
    logic [KEY_W-1:0] key;
  } eng_cmd_t;

  // Result of one engine pass
  typedef struct packed {
    logic [2:0]          status;
    logic [REF_BITS-1:0] refs;
    logic [CNT_W-1:0]    removed;
  } eng_res_t;

endpackage

FILE: src/reference_count_aging_table.sv
// Top level of the reference count aging table: handshakes, marks and result register.
//
// A request that the water marks decide at once (a reference refused at the
// high mark, a checked clean skipped at the low mark) is loaded into the result
// register at its transfer and answered in the next cycle. Every other request
// runs one pass of the scan engine, which reads the entry memory one entry per
// cycle through its single read port and updates counts through one shared
// increment/decrement unit: a miss or a clean walks every slot, while a hit
// ends the pass at its slot. The block takes no new request while a pass is
// running, nor while a result waits in the result register, unless that result
// is transferred in the same cycle.
module reference_count_aging_table
  import rcat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [MARK_W-1:0]   cfg_data,
  // requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic signed [KEY_W-1:0] key,
  input  logic                check_level,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [15:0]         ref_after,
  output logic [6:0]          occupancy,
  output logic [6:0]          removed,
  output logic                clean_wanted,
  output logic                room_left
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_BUSY = 2'd1;
  localparam logic [1:0] T_PUT  = 2'd2;

  logic [1:0]        state;
  logic [MARK_W-1:0] high_mark;
  logic [MARK_W-1:0] low_mark;

  logic              acc;
  logic              out_free;
  logic              load_res;
  logic [CMP_W-1:0]  held_x;
  logic [CMP_W-1:0]  limit;
  logic              refuse;
  logic              skip;
  logic              start;
  eng_cmd_t          cmd;
  logic              eng_done;
  eng_res_t          eng_res;
  logic [CNT_W-1:0]  held;

  rcat_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .done  (eng_done),
    .res   (eng_res),
    .held  (held)
  );

  // Mark decisions on the current occupancy
  assign held_x   = CMP_W'(held);
  assign limit    = (CMP_W'(high_mark) < CMP_W'(CAPACITY)) ? CMP_W'(high_mark)
                                                           : CMP_W'(CAPACITY);
  assign refuse   = (held_x >= limit);
  assign skip     = check_level && (held_x <= CMP_W'(low_mark));

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == T_IDLE) && out_free;
  assign acc      = in_valid && in_ready;

  assign cmd.clean = (req_type == REQ_CLEAN);
  assign cmd.key   = key;
  assign start     = acc && ((req_type == REQ_REF) ? !refuse : !skip);

  // Load the result register on an immediate answer or at the end of a pass
  assign load_res = ((state == T_IDLE) && acc && !start) || ((state == T_PUT) && out_free);

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_mark <= MARK_W'(64);
      low_mark  <= MARK_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_MARK: high_mark <= cfg_data;
        REG_LOW_MARK:  low_mark  <= cfg_data;
        default:       high_mark <= high_mark;
      endcase
    end
  end

  // Sequence requests and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (acc) begin
            if (start) begin
              state <= T_BUSY;
            end else begin
              status       <= (req_type == REQ_REF) ? ST_REFUSED : ST_SKIPPED;
              ref_after    <= '0;
              occupancy    <= 7'(held);
              removed      <= '0;
              clean_wanted <= (held_x > CMP_W'(low_mark));
              room_left    <= (held_x < limit);
            end
          end
        end
        T_BUSY: begin
          if (eng_done) begin
            state <= T_PUT;
          end
        end
        T_PUT: begin
          if (out_free) begin
            status       <= eng_res.status;
            ref_after    <= 16'(eng_res.refs);
            occupancy    <= 7'(held);
            removed      <= 7'(eng_res.removed);
            clean_wanted <= (held_x > CMP_W'(low_mark));
            room_left    <= (held_x < limit);
            state        <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // A pass ends only while the front end waits for it
  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> (state == T_BUSY))
    else $error("engine finished outside a pass");

  // A started pass leaves the front end busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == T_BUSY))
    else $error("pass started without going busy");

  // Result codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_SKIPPED))
    else $error("undefined status code");

endmodule

FILE: src/rcat_ram.sv
// Entry memory: keys and counts, one write port and one registered read port.
module rcat_ram
  import rcat_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  ent_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output ent_t             rdata
);

  ent_t mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/rcat_engine.sv
// Scan engine: walks the table one entry per cycle through a shared count unit.
module rcat_engine
  import rcat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  eng_cmd_t         cmd,
  output logic             done,
  output eng_res_t         res,
  output logic [CNT_W-1:0] held
);

  localparam logic E_IDLE = 1'b0;
  localparam logic E_SCAN = 1'b1;

  logic                state;
  eng_cmd_t            cmd_q;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    ev_idx;
  logic                ev_pend;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [CNT_W-1:0]    removed_cnt;

  logic                scan_end;
  logic                ev_v;
  logic                match;
  logic [REF_BITS-1:0] upd_refs;
  logic [REF_BITS-1:0] unit_sum;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  ent_t                wdata;
  ent_t                rdata;

  rcat_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Evaluate the entry whose read came back this cycle
  assign scan_end = (state == E_SCAN) && !ev_pend && (rd_idx == CNT_W'(CAPACITY));
  assign ev_v     = valid[ev_idx];
  assign match    = ev_v && (rdata.key == cmd_q.key);

  // Shared count unit: step up on a reference, down on a clean; hold at the top
  assign unit_sum = rdata.refs + (cmd_q.clean ? REF_MAX : REF_ONE);
  assign upd_refs = (!cmd_q.clean && rdata.refs == REF_MAX) ? REF_MAX : unit_sum;

  // Write back a changed count, or place a new key at the end of a missed lookup
  always_comb begin
    we    = 1'b0;
    waddr = ev_idx;
    wdata = '{key: rdata.key, refs: upd_refs};
    if (state == E_SCAN && ev_pend) begin
      if (cmd_q.clean) begin
        we = ev_v && (rdata.refs > REF_ONE);
      end else begin
        we = match;
      end
    end else if (scan_end && !cmd_q.clean && free_found) begin
      we    = 1'b1;
      waddr = free_idx;
      wdata = '{key: cmd_q.key, refs: REF_ONE};
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= E_IDLE;
      valid       <= '0;
      held        <= '0;
      done        <= 1'b0;
      ev_pend     <= 1'b0;
      rd_idx      <= '0;
      free_found  <= 1'b0;
      removed_cnt <= '0;
    end else begin
      case (state)
        E_IDLE: begin
          done <= 1'b0;
          if (start) begin
            cmd_q       <= cmd;
            rd_idx      <= '0;
            ev_pend     <= 1'b0;
            free_found  <= 1'b0;
            removed_cnt <= '0;
            state       <= E_SCAN;
          end
        end
        E_SCAN: begin
          // advance the read side
          if (rd_idx != CNT_W'(CAPACITY)) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            ev_idx  <= rd_idx[IDX_W-1:0];
            ev_pend <= 1'b1;
          end else begin
            ev_pend <= 1'b0;
          end
          if (ev_pend) begin
            if (cmd_q.clean) begin
              // drop entries whose count runs out
              if (ev_v && rdata.refs <= REF_ONE) begin
                valid[ev_idx] <= 1'b0;
                removed_cnt   <= removed_cnt + CNT_W'(1);
              end
            end else if (match) begin
              res.status  <= ST_HIT;
              res.refs    <= upd_refs;
              res.removed <= '0;
              done        <= 1'b1;
              state       <= E_IDLE;
            end else if (!ev_v && !free_found) begin
              // remember the lowest free slot
              free_found <= 1'b1;
              free_idx   <= ev_idx;
            end
          end else if (scan_end) begin
            done  <= 1'b1;
            state <= E_IDLE;
            if (cmd_q.clean) begin
              held        <= held - removed_cnt;
              res.status  <= ST_CLEANED;
              res.refs    <= '0;
              res.removed <= removed_cnt;
            end else if (free_found) begin
              valid[free_idx] <= 1'b1;
              held            <= held + CNT_W'(1);
              res.status      <= ST_INSERTED;
              res.refs        <= REF_ONE;
              res.removed     <= '0;
            end else begin
              res.status  <= ST_REFUSED;
              res.refs    <= '0;
              res.removed <= '0;
            end
          end
        end
        default: begin
          done  <= 1'b0;
          state <= E_IDLE;
        end
      endcase
    end
  end

  // Held count tracks the valid bits between passes
  a_held_matches: assert property (@(posedge clk) disable iff (rst)
    (state == E_IDLE) |-> (int'(held) == $countones(valid)))
    else $error("held count differs from valid bits");

  // Held count never exceeds the table
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // Memory is written only during a pass
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == E_SCAN))
    else $error("entry write outside a pass");

  // Completion is a single-cycle pulse that leaves the engine idle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == E_IDLE && !$past(done)))
    else $error("done not a clean pulse");

endmodule
